/* src/assert_macros.svh */
// Assertion macros for the frame header decoder; only fhld_decode includes them.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* src/fhld_pkg.sv */
// Package for the frame header and length decoder: types and constants.
// No dependencies; used by all fhld modules and the top level.
`default_nettype none

package fhld_pkg;

   localparam int BYTE_WIDTH       = 8;
   localparam int LENGTH_WIDTH     = 64;
   localparam int MAX_LENGTH_WIDTH = 63;
   localparam int COUNT_WIDTH      = 4;
   localparam int FLAGS_WIDTH      = 3;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = 64;

   localparam int FLAG_MORE_BIT    = 0;
   localparam int FLAG_LARGE_BIT   = 1;
   localparam int FLAG_COMMAND_BIT = 2;

   localparam logic [COUNT_WIDTH-1:0] LONG_LENGTH_BYTES  = 4'd8;
   localparam logic [COUNT_WIDTH-1:0] SHORT_LENGTH_BYTES = 4'd1;

   typedef enum logic [1:0] {
      PHASE_FLAGS   = 2'd0,
      PHASE_LENGTH  = 2'd1,
      PHASE_PAYLOAD = 2'd2,
      PHASE_ERROR   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LIMIT_ENABLE = 2'd0,
      CSR_MAX_LENGTH   = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic                        limit_enable;
      logic [MAX_LENGTH_WIDTH-1:0] max_length;
   } cfg_type;

   typedef struct packed {
      kind_type                kind;
      logic [LENGTH_WIDTH-1:0] frame_length;
      logic                    more_bit;
      logic                    command_bit;
      logic [BYTE_WIDTH-1:0]   payload;
      logic                    last;
   } result_type;

endpackage

`default_nettype wire

/* src/fhld_in_stage.sv */
// Input register of the frame header decoder: holds one accepted byte.
// Depends on fhld_pkg.
`default_nettype none

module fhld_in_stage (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [fhld_pkg::BYTE_WIDTH-1:0] req_data_byte,
   input  wire logic                           fire,
   output logic                                in_valid,
   output logic [fhld_pkg::BYTE_WIDTH-1:0]     in_byte
);

   logic                            in_valid_ff;
   logic                            in_valid_in;
   logic [fhld_pkg::BYTE_WIDTH-1:0] in_byte_ff;
   logic [fhld_pkg::BYTE_WIDTH-1:0] in_byte_in;
   logic                            take;

   assign req_ready = !in_valid_ff || fire;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   assign in_valid = in_valid_ff;
   assign in_byte  = in_byte_ff;

endmodule

`default_nettype wire

/* src/fhld_decode.sv */
// Frame parser state and next-state logic for one byte per cycle while the result register is free.
// Depends on fhld_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fhld_decode (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic [fhld_pkg::BYTE_WIDTH-1:0] in_byte,
   input  wire logic                           out_free,
   input  wire fhld_pkg::cfg_type              cfg,
   output logic                                fire,
   output logic                                res_valid,
   output fhld_pkg::result_type                res
);

   fhld_pkg::phase_type                phase_ff;
   fhld_pkg::phase_type                phase_in;
   logic [fhld_pkg::FLAGS_WIDTH-1:0]   flags_ff;
   logic [fhld_pkg::FLAGS_WIDTH-1:0]   flags_in;
   logic [fhld_pkg::LENGTH_WIDTH-1:0]  shift_ff;
   logic [fhld_pkg::LENGTH_WIDTH-1:0]  shift_in;
   logic [fhld_pkg::COUNT_WIDTH-1:0]   bytes_left_ff;
   logic [fhld_pkg::COUNT_WIDTH-1:0]   bytes_left_in;
   logic [fhld_pkg::LENGTH_WIDTH-1:0]  payload_left_ff;
   logic [fhld_pkg::LENGTH_WIDTH-1:0]  payload_left_in;

   logic [fhld_pkg::LENGTH_WIDTH-1:0]  shifted;
   logic [fhld_pkg::COUNT_WIDTH-1:0]   bytes_left_dec;
   logic [fhld_pkg::LENGTH_WIDTH-1:0]  payload_left_dec;
   logic                               too_long;
   logic                               fin;

   assign fire = in_valid && out_free;

   assign shifted = {shift_ff[fhld_pkg::LENGTH_WIDTH-fhld_pkg::BYTE_WIDTH-1:0], in_byte};
   assign bytes_left_dec = (bytes_left_ff != '0) ?
                           bytes_left_ff - {{(fhld_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1} : '0;
   assign payload_left_dec = (payload_left_ff != '0) ?
                             payload_left_ff - {{(fhld_pkg::LENGTH_WIDTH-1){1'b0}}, 1'b1} : '0;
   assign too_long = cfg.limit_enable && (shifted > {1'b0, cfg.max_length});
   assign fin = (payload_left_ff <= {{(fhld_pkg::LENGTH_WIDTH-1){1'b0}}, 1'b1});

   always_comb begin
      phase_in        = phase_ff;
      flags_in        = flags_ff;
      shift_in        = shift_ff;
      bytes_left_in   = bytes_left_ff;
      payload_left_in = payload_left_ff;
      res_valid       = 1'b0;
      res.kind        = fhld_pkg::KIND_HEADER;
      res.frame_length = '0;
      res.more_bit    = flags_ff[fhld_pkg::FLAG_MORE_BIT];
      res.command_bit = flags_ff[fhld_pkg::FLAG_COMMAND_BIT];
      res.payload     = '0;
      res.last        = 1'b0;
      case (phase_ff)
         fhld_pkg::PHASE_FLAGS: begin
            flags_in      = in_byte[fhld_pkg::FLAGS_WIDTH-1:0];
            shift_in      = '0;
            bytes_left_in = in_byte[fhld_pkg::FLAG_LARGE_BIT] ?
                            fhld_pkg::LONG_LENGTH_BYTES : fhld_pkg::SHORT_LENGTH_BYTES;
            phase_in      = fhld_pkg::PHASE_LENGTH;
         end
         fhld_pkg::PHASE_LENGTH: begin
            shift_in      = shifted;
            bytes_left_in = bytes_left_dec;
            if (bytes_left_dec == '0) begin
               res_valid        = 1'b1;
               res.frame_length = shifted;
               if (too_long) begin
                  phase_in = fhld_pkg::PHASE_ERROR;
                  res.kind = fhld_pkg::KIND_ERROR;
               end else if (shifted == '0) begin
                  phase_in = fhld_pkg::PHASE_FLAGS;
                  res.last = 1'b1;
               end else begin
                  phase_in        = fhld_pkg::PHASE_PAYLOAD;
                  payload_left_in = shifted;
               end
            end
         end
         fhld_pkg::PHASE_PAYLOAD: begin
            payload_left_in = payload_left_dec;
            if (fin) begin
               phase_in = fhld_pkg::PHASE_FLAGS;
            end
            res_valid   = 1'b1;
            res.kind    = fhld_pkg::KIND_PAYLOAD;
            res.payload = in_byte;
            res.last    = fin;
         end
         default: begin
            phase_in = fhld_pkg::PHASE_ERROR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= fhld_pkg::PHASE_FLAGS;
         flags_ff        <= '0;
         shift_ff        <= '0;
         bytes_left_ff   <= '0;
         payload_left_ff <= '0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         flags_ff        <= flags_in;
         shift_ff        <= shift_in;
         bytes_left_ff   <= bytes_left_in;
         payload_left_ff <= payload_left_in;
      end
   end

   `ASSERT_NEXT(a_error_sticky, clock, reset,
                phase_ff == fhld_pkg::PHASE_ERROR, phase_ff == fhld_pkg::PHASE_ERROR)
   `ASSERT_ALWAYS(a_payload_count_nonzero, clock, reset,
                  phase_ff != fhld_pkg::PHASE_PAYLOAD || payload_left_ff != '0)
   `ASSERT_ALWAYS(a_length_count_nonzero, clock, reset,
                  phase_ff != fhld_pkg::PHASE_LENGTH || bytes_left_ff != '0)

endmodule

`default_nettype wire

/* src/fhld_out_stage.sv */
// Result register of the frame header decoder with its output handshake.
// Depends on fhld_pkg.
`default_nettype none

module fhld_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire logic                 res_valid,
   input  wire fhld_pkg::result_type res,
   input  wire logic                 rsp_ready,
   output logic                      out_free,
   output logic                      rsp_valid,
   output fhld_pkg::result_type      rsp_res
);

   logic                 out_valid_ff;
   logic                 out_valid_in;
   fhld_pkg::result_type out_res_ff;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = fire && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res_valid) begin
         out_res_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_res   = out_res_ff;

endmodule

`default_nettype wire

/* src/frame_header_length_decoder.sv */
// Frame header and length decoder: one byte per item, at most one result item per byte.
// A byte is held in the input register; its result is then registered in the result register.
// One byte per cycle while the result register is free or rsp_ready is high; otherwise the byte stalls.
// Reset (synchronous): parser waits for a flags byte, length limit is off, both registers empty.
// Depends on fhld_pkg, fhld_in_stage, fhld_decode and fhld_out_stage.
`default_nettype none

module frame_header_length_decoder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [fhld_pkg::BYTE_WIDTH-1:0]      req_data_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_kind,
   output logic [fhld_pkg::LENGTH_WIDTH-1:0]        rsp_frame_length,
   output logic                                     rsp_more_bit,
   output logic                                     rsp_command_bit,
   output logic [fhld_pkg::BYTE_WIDTH-1:0]          rsp_payload,
   output logic                                     rsp_last,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [fhld_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [fhld_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   fhld_pkg::cfg_type               cfg_ff;
   fhld_pkg::cfg_type               cfg_in;
   logic                            fire;
   logic                            in_valid;
   logic [fhld_pkg::BYTE_WIDTH-1:0] in_byte;
   logic                            out_free;
   logic                            res_valid;
   fhld_pkg::result_type            res;
   fhld_pkg::result_type            rsp_res;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            fhld_pkg::CSR_LIMIT_ENABLE: begin
               cfg_in.limit_enable = csr_data[0];
            end
            fhld_pkg::CSR_MAX_LENGTH: begin
               cfg_in.max_length = csr_data[fhld_pkg::MAX_LENGTH_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fhld_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .fire          (fire),
      .in_valid      (in_valid),
      .in_byte       (in_byte)
   );

   fhld_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_byte   (in_byte),
      .out_free  (out_free),
      .cfg       (cfg_ff),
      .fire      (fire),
      .res_valid (res_valid),
      .res       (res)
   );

   fhld_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .res_valid (res_valid),
      .res       (res),
      .rsp_ready (rsp_ready),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_res   (rsp_res)
   );

   assign rsp_kind         = rsp_res.kind;
   assign rsp_frame_length = rsp_res.frame_length;
   assign rsp_more_bit     = rsp_res.more_bit;
   assign rsp_command_bit  = rsp_res.command_bit;
   assign rsp_payload      = rsp_res.payload;
   assign rsp_last         = rsp_res.last;

endmodule

`default_nettype wire
